// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the compensation RTL.
// No dependencies; define NO_ASSERTIONS to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)

`define ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

// ----- rtl/core/ptc_pkg.sv -----
// Package for the pressure/temperature compensation pipeline.
// Holds field widths, internal widths, limits, status and register codes; no dependencies.
`timescale 1ns / 1ps

package ptc_pkg;

    // Port widths
    localparam int RAW_W     = 24;
    localparam int COEF_W    = 16;
    localparam int REG_IDX_W = 3;
    localparam int TEMP_W    = 19;
    localparam int PRES_W    = 24;
    localparam int STATUS_W  = 2;

    // Internal widths, sized from the worst-case ranges of each term
    localparam int DT_W        = 25;
    localparam int CPROD_W     = 42;
    localparam int DTSQ_W      = 50;
    localparam int TI_FULL_W   = 54;
    localparam int TI_W        = 17;
    localparam int TEMP1_W     = 20;
    localparam int OFF_W       = 38;
    localparam int SENS_W      = 38;
    localparam int DSQ_W       = 40;
    localparam int CORR_W      = 41;
    localparam int SENS_LO_W   = 19;
    localparam int SENS_HI_W   = SENS_W - SENS_LO_W;
    localparam int PL_W        = RAW_W + SENS_LO_W;
    localparam int PH_W        = RAW_W + 1 + SENS_HI_W;
    localparam int SUM_W       = 63;
    localparam int Q1_W        = 42;
    localparam int X_W         = 43;
    localparam int PRES_FULL_W = 28;

    // Register stages from input capture to the result strobe
    localparam int PIPE_DEPTH = 10;

    localparam logic [RAW_W-1:0] RAW_ALL_ONES = {RAW_W{1'b1}};

    localparam int TEMP_REF = 2000;
    localparam int TEMP_MIN = -4000;
    localparam int TEMP_MAX = 8500;
    localparam int PRES_MIN = 1000;
    localparam int PRES_MAX = 200000;
    localparam int TEMP_SAT_MIN = -(1 << (TEMP_W - 1));
    localparam int TEMP_SAT_MAX = (1 << (TEMP_W - 1)) - 1;
    localparam int PRES_SAT_MIN = -(1 << (PRES_W - 1));
    localparam int PRES_SAT_MAX = (1 << (PRES_W - 1)) - 1;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK        = 2'd0,
        STATUS_ADC_ERR   = 2'd1,
        STATUS_RANGE_ERR = 2'd2
    } status_t;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_C1 = 3'd0,
        REG_C2 = 3'd1,
        REG_C3 = 3'd2,
        REG_C4 = 3'd3,
        REG_C5 = 3'd4,
        REG_C6 = 3'd5
    } reg_index_t;

endpackage

// ----- rtl/core/pressure_temperature_compensation_unit.sv -----
// Second-order pressure/temperature compensation, fully pipelined top level.
// Depends on ptc_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Channel  | Handshake          | Payload
// ---------+--------------------+-----------------------------------------
// input    | start / busy       | pressure_code, temperature_code
// result   | done (1-cycle)     | temperature, pressure, status
// config   | cfg_we             | cfg_index, cfg_data (16 bits)
//
// A transaction is taken in every cycle that start is high; busy is always low.
// done is the last bit of the valid chain, which runs alongside the data through
// the PIPE_DEPTH (10) register stages, with the full multipliers in stages two,
// four and six and the wide adds spread over the rest.
// Throughput is one transaction per cycle. The pipeline never stalls.
// rst_n clears the valid chain and the six coefficient registers to zero.

module pressure_temperature_compensation_unit (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic        [ptc_pkg::RAW_W-1:0]      pressure_code,
    input  logic        [ptc_pkg::RAW_W-1:0]      temperature_code,
    output logic                                  done,
    output logic signed [ptc_pkg::TEMP_W-1:0]     temperature,
    output logic signed [ptc_pkg::PRES_W-1:0]     pressure,
    output logic        [ptc_pkg::STATUS_W-1:0]   status,
    input  logic                                  cfg_we,
    input  logic        [ptc_pkg::REG_IDX_W-1:0]  cfg_index,
    input  logic        [ptc_pkg::COEF_W-1:0]     cfg_data
);

    import ptc_pkg::*;

    logic accept;

    logic [COEF_W-1:0] c1_reg, c2_reg, c3_reg, c4_reg, c5_reg, c6_reg;
    logic [PIPE_DEPTH-1:0] valid_reg;

    // Stage 1: raw capture and dT
    logic        [RAW_W-1:0] s1_d1_reg;
    logic                    s1_bad_reg, s1_bad_next;
    logic signed [DT_W-1:0]  s1_dt_reg, s1_dt_next;

    // Stage 2: coefficient products and dT squared
    logic        [RAW_W-1:0]   s2_d1_reg;
    logic                      s2_bad_reg;
    logic signed [CPROD_W-1:0] s2_p6_reg, s2_p6_next;
    logic signed [CPROD_W-1:0] s2_p4_reg, s2_p4_next;
    logic signed [CPROD_W-1:0] s2_p3_reg, s2_p3_next;
    logic signed [DTSQ_W-1:0]  s2_dtsq_reg, s2_dtsq_next;

    // Stage 3: first-order terms
    logic        [RAW_W-1:0]   s3_d1_reg;
    logic                      s3_bad_reg;
    logic signed [TEMP1_W-1:0] s3_temp1_reg, s3_temp1_next;
    logic signed [OFF_W-1:0]   s3_off1_reg, s3_off1_next;
    logic signed [SENS_W-1:0]  s3_sens1_reg, s3_sens1_next;
    logic        [TI_W-1:0]    s3_ti_reg, s3_ti_next;
    logic signed [CPROD_W-1:0] p6_bias, p4_bias, p3_bias;
    logic        [TI_FULL_W-1:0] ti_full;

    // Stage 4: low-temperature test, temperature correction, diff squared
    logic        [RAW_W-1:0]   s4_d1_reg;
    logic                      s4_bad_reg;
    logic                      s4_low_reg, s4_low_next;
    logic signed [TEMP1_W-1:0] s4_temp2_reg, s4_temp2_next;
    logic signed [DSQ_W-1:0]   s4_dsq_reg, s4_dsq_next;
    logic signed [OFF_W-1:0]   s4_off1_reg;
    logic signed [SENS_W-1:0]  s4_sens1_reg;
    logic signed [TEMP1_W-1:0] diff;

    // Stage 5: second-order offset and sensitivity
    logic        [RAW_W-1:0]   s5_d1_reg;
    logic                      s5_bad_reg;
    logic signed [TEMP1_W-1:0] s5_temp2_reg;
    logic signed [OFF_W-1:0]   s5_off2_reg, s5_off2_next;
    logic signed [SENS_W-1:0]  s5_sens2_reg, s5_sens2_next;
    logic        [CORR_W-1:0]  off_corr_full, sens_corr_full;

    // Stage 6: partial products of D1 * SENS
    logic                      s6_bad_reg;
    logic signed [TEMP1_W-1:0] s6_temp2_reg;
    logic signed [OFF_W-1:0]   s6_off2_reg;
    logic        [PL_W-1:0]    s6_pl_reg, s6_pl_next;
    logic signed [PH_W-1:0]    s6_ph_reg, s6_ph_next;

    // Stage 7: product sum
    logic                      s7_bad_reg;
    logic signed [TEMP1_W-1:0] s7_temp2_reg;
    logic signed [OFF_W-1:0]   s7_off2_reg;
    logic signed [SUM_W-1:0]   s7_sum_reg, s7_sum_next;

    // Stage 8: scale by 2^-21
    logic                      s8_bad_reg;
    logic signed [TEMP1_W-1:0] s8_temp2_reg;
    logic signed [OFF_W-1:0]   s8_off2_reg;
    logic signed [Q1_W-1:0]    s8_q1_reg, s8_q1_next;
    logic signed [SUM_W-1:0]   sum_bias;

    // Stage 9: subtract offset
    logic                      s9_bad_reg;
    logic signed [TEMP1_W-1:0] s9_temp2_reg;
    logic signed [X_W-1:0]     s9_x_reg, s9_x_next;

    // Stage 10: scale, range check, saturate
    logic signed [X_W-1:0]         x_bias;
    logic signed [PRES_FULL_W-1:0] pres_full;
    logic                          out_of_range;
    logic signed [TEMP_W-1:0]      temperature_next;
    logic signed [PRES_W-1:0]      pressure_next;
    status_t                       status_next;

    // Result classification for the checks below
    logic pres_in_window, temp_in_window;
    logic result_ok, result_adc_err, result_range_err;

    assign busy   = 1'b0;
    assign accept = start & ~busy;
    assign done   = valid_reg[PIPE_DEPTH-1];

    // ---------------- configuration registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_reg <= '0;
            c2_reg <= '0;
            c3_reg <= '0;
            c4_reg <= '0;
            c5_reg <= '0;
            c6_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_C1:  c1_reg <= cfg_data;
                REG_C2:  c2_reg <= cfg_data;
                REG_C3:  c3_reg <= cfg_data;
                REG_C4:  c4_reg <= cfg_data;
                REG_C5:  c5_reg <= cfg_data;
                REG_C6:  c6_reg <= cfg_data;
                default: ;  // drop writes beyond the register list
            endcase
        end
    end

    // ---------------- valid chain ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[PIPE_DEPTH-2:0], accept};
        end
    end

    // ---------------- datapath logic ----------------
    always_comb
    begin
        // Stage 1
        s1_bad_next = (pressure_code == '0) || (pressure_code == RAW_ALL_ONES) ||
                      (temperature_code == '0) || (temperature_code == RAW_ALL_ONES);
        s1_dt_next  = $signed({1'b0, temperature_code}) - $signed({1'b0, c5_reg, 8'h00});

        // Stage 2
        s2_p6_next   = s1_dt_reg * $signed({1'b0, c6_reg});
        s2_p4_next   = s1_dt_reg * $signed({1'b0, c4_reg});
        s2_p3_next   = s1_dt_reg * $signed({1'b0, c3_reg});
        s2_dtsq_next = s1_dt_reg * s1_dt_reg;

        // Stage 3: bias negative values so the shifts truncate toward zero
        p6_bias = s2_p6_reg + $signed({{(CPROD_W-23){1'b0}}, {23{s2_p6_reg[CPROD_W-1]}}});
        p4_bias = s2_p4_reg + $signed({{(CPROD_W-6){1'b0}}, {6{s2_p4_reg[CPROD_W-1]}}});
        p3_bias = s2_p3_reg + $signed({{(CPROD_W-7){1'b0}}, {7{s2_p3_reg[CPROD_W-1]}}});
        s3_temp1_next = TEMP1_W'(p6_bias >>> 23) + TEMP1_W'(TEMP_REF);
        s3_off1_next  = $signed(OFF_W'({c2_reg, 17'b0})) + OFF_W'(p4_bias >>> 6);
        s3_sens1_next = $signed(SENS_W'({c1_reg, 16'b0})) + SENS_W'(p3_bias >>> 7);
        // dT squared is never negative: plain shift
        ti_full    = TI_FULL_W'(s2_dtsq_reg[DTSQ_W-2:0]) * TI_FULL_W'(11);
        s3_ti_next = TI_W'(ti_full >> 35);

        // Stage 4
        s4_low_next   = s3_temp1_reg < TEMP1_W'(TEMP_REF);
        diff          = s3_temp1_reg - TEMP1_W'(TEMP_REF);
        s4_dsq_next   = diff * diff;
        s4_temp2_next = s4_low_next ? s3_temp1_reg - $signed(TEMP1_W'(s3_ti_reg))
                                    : s3_temp1_reg;

        // Stage 5
        off_corr_full  = CORR_W'(s4_dsq_reg[DSQ_W-2:0]) * CORR_W'(31);
        sens_corr_full = CORR_W'(s4_dsq_reg[DSQ_W-2:0]) * CORR_W'(63);
        s5_off2_next   = s4_low_reg ? s4_off1_reg - $signed(OFF_W'(off_corr_full >> 3))
                                    : s4_off1_reg;
        s5_sens2_next  = s4_low_reg ? s4_sens1_reg - $signed(SENS_W'(sens_corr_full >> 5))
                                    : s4_sens1_reg;

        // Stage 6: split SENS into an unsigned low and a signed high slice
        s6_pl_next = PL_W'(s5_d1_reg) * PL_W'(s5_sens2_reg[SENS_LO_W-1:0]);
        s6_ph_next = $signed({1'b0, s5_d1_reg}) * $signed(s5_sens2_reg[SENS_W-1:SENS_LO_W]);

        // Stage 7
        s7_sum_next = ($signed(SUM_W'(s6_ph_reg)) <<< SENS_LO_W) + $signed(SUM_W'(s6_pl_reg));

        // Stage 8
        sum_bias   = s7_sum_reg + $signed({{(SUM_W-21){1'b0}}, {21{s7_sum_reg[SUM_W-1]}}});
        s8_q1_next = Q1_W'(sum_bias >>> 21);

        // Stage 9
        s9_x_next = X_W'(s8_q1_reg) - X_W'(s8_off2_reg);

        // Stage 10
        x_bias    = s9_x_reg + $signed({{(X_W-15){1'b0}}, {15{s9_x_reg[X_W-1]}}});
        pres_full = PRES_FULL_W'(x_bias >>> 15);

        out_of_range = (pres_full < PRES_FULL_W'(PRES_MIN)) ||
                       (pres_full > PRES_FULL_W'(PRES_MAX)) ||
                       (s9_temp2_reg < TEMP1_W'(TEMP_MIN)) ||
                       (s9_temp2_reg > TEMP1_W'(TEMP_MAX));

        if (s9_temp2_reg < TEMP1_W'(TEMP_SAT_MIN))
            temperature_next = TEMP_W'(TEMP_SAT_MIN);
        else if (s9_temp2_reg > TEMP1_W'(TEMP_SAT_MAX))
            temperature_next = TEMP_W'(TEMP_SAT_MAX);
        else
            temperature_next = TEMP_W'(s9_temp2_reg);

        if (pres_full < PRES_FULL_W'(PRES_SAT_MIN))
            pressure_next = PRES_W'(PRES_SAT_MIN);
        else if (pres_full > PRES_FULL_W'(PRES_SAT_MAX))
            pressure_next = PRES_W'(PRES_SAT_MAX);
        else
            pressure_next = PRES_W'(pres_full);

        status_next = out_of_range ? STATUS_RANGE_ERR : STATUS_OK;

        // Invalid conversion overrides everything
        if (s9_bad_reg)
        begin
            temperature_next = '0;
            pressure_next    = '0;
            status_next      = STATUS_ADC_ERR;
        end
    end

    // ---------------- pipeline registers ----------------
    always_ff @(posedge clk)
    begin
        s1_d1_reg  <= pressure_code;
        s1_bad_reg <= s1_bad_next;
        s1_dt_reg  <= s1_dt_next;

        s2_d1_reg   <= s1_d1_reg;
        s2_bad_reg  <= s1_bad_reg;
        s2_p6_reg   <= s2_p6_next;
        s2_p4_reg   <= s2_p4_next;
        s2_p3_reg   <= s2_p3_next;
        s2_dtsq_reg <= s2_dtsq_next;

        s3_d1_reg    <= s2_d1_reg;
        s3_bad_reg   <= s2_bad_reg;
        s3_temp1_reg <= s3_temp1_next;
        s3_off1_reg  <= s3_off1_next;
        s3_sens1_reg <= s3_sens1_next;
        s3_ti_reg    <= s3_ti_next;

        s4_d1_reg    <= s3_d1_reg;
        s4_bad_reg   <= s3_bad_reg;
        s4_low_reg   <= s4_low_next;
        s4_temp2_reg <= s4_temp2_next;
        s4_dsq_reg   <= s4_dsq_next;
        s4_off1_reg  <= s3_off1_reg;
        s4_sens1_reg <= s3_sens1_reg;

        s5_d1_reg    <= s4_d1_reg;
        s5_bad_reg   <= s4_bad_reg;
        s5_temp2_reg <= s4_temp2_reg;
        s5_off2_reg  <= s5_off2_next;
        s5_sens2_reg <= s5_sens2_next;

        s6_bad_reg   <= s5_bad_reg;
        s6_temp2_reg <= s5_temp2_reg;
        s6_off2_reg  <= s5_off2_reg;
        s6_pl_reg    <= s6_pl_next;
        s6_ph_reg    <= s6_ph_next;

        s7_bad_reg   <= s6_bad_reg;
        s7_temp2_reg <= s6_temp2_reg;
        s7_off2_reg  <= s6_off2_reg;
        s7_sum_reg   <= s7_sum_next;

        s8_bad_reg   <= s7_bad_reg;
        s8_temp2_reg <= s7_temp2_reg;
        s8_off2_reg  <= s7_off2_reg;
        s8_q1_reg    <= s8_q1_next;

        s9_bad_reg   <= s8_bad_reg;
        s9_temp2_reg <= s8_temp2_reg;
        s9_x_reg     <= s9_x_next;

        temperature <= temperature_next;
        pressure    <= pressure_next;
        status      <= status_next;
    end

    // ---------------- assertions ----------------
    assign pres_in_window   = (pressure >= PRES_W'(PRES_MIN)) && (pressure <= PRES_W'(PRES_MAX));
    assign temp_in_window   = (temperature >= TEMP_W'(TEMP_MIN)) &&
                              (temperature <= TEMP_W'(TEMP_MAX));
    assign result_ok        = done && (status == STATUS_OK);
    assign result_adc_err   = done && (status == STATUS_ADC_ERR);
    assign result_range_err = done && (status == STATUS_RANGE_ERR);

    `ASSERT_IMPLIES(a_done_latency, clk, rst_n, done, $past(start, PIPE_DEPTH))
    `ASSERT_IMPLIES(a_adc_err_zero, clk, rst_n, result_adc_err, temperature == '0 && pressure == '0)
    `ASSERT_IMPLIES(a_ok_pres_range, clk, rst_n, result_ok, pres_in_window)
    `ASSERT_IMPLIES(a_ok_temp_range, clk, rst_n, result_ok, temp_in_window)
    `ASSERT_NEVER(a_range_err_cause, clk, rst_n, result_range_err && pres_in_window && temp_in_window)

endmodule

// ----- sim/compensation_checker.sv -----
// Checker for the pressure/temperature compensation unit: mirrors the coefficient
// registers, predicts each reading and compares it with the result strobe.
// Depends on ptc_pkg.
`timescale 1ns / 1ps

module compensation_checker (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic                                  busy,
    input  logic        [ptc_pkg::RAW_W-1:0]      pressure_code,
    input  logic        [ptc_pkg::RAW_W-1:0]      temperature_code,
    input  logic                                  done,
    input  logic signed [ptc_pkg::TEMP_W-1:0]     temperature,
    input  logic signed [ptc_pkg::PRES_W-1:0]     pressure,
    input  logic        [ptc_pkg::STATUS_W-1:0]   status,
    input  logic                                  cfg_we,
    input  logic        [ptc_pkg::REG_IDX_W-1:0]  cfg_index,
    input  logic        [ptc_pkg::COEF_W-1:0]     cfg_data,
    output int                                    mismatches,
    output int                                    pending,
    output int                                    readings_checked
);

    import ptc_pkg::*;

    localparam int REPORT_LIMIT = 10;

    localparam longint REF_TEMP_MUL = 64'sd256;
    localparam longint DT_TEMP_DIV  = 64'sd8388608;
    localparam longint OFF_MUL      = 64'sd131072;
    localparam longint OFF_TC_DIV   = 64'sd64;
    localparam longint SENS_MUL     = 64'sd65536;
    localparam longint SENS_TC_DIV  = 64'sd128;
    localparam longint TI_MUL       = 64'sd11;
    localparam longint TI_DIV       = 64'sd34359738368;
    localparam longint OFFI_MUL     = 64'sd31;
    localparam longint OFFI_DIV     = 64'sd8;
    localparam longint SENSI_MUL    = 64'sd63;
    localparam longint SENSI_DIV    = 64'sd32;
    localparam longint P_SENS_DIV   = 64'sd2097152;
    localparam longint P_DIV        = 64'sd32768;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temperature;
        logic signed [PRES_W-1:0] pressure;
        status_t                  status;
    } reading_t;

    logic [COEF_W-1:0] coef [6];
    reading_t          expected_readings [$];
    int                mismatch_count;
    int                checked_count;

    function automatic reading_t compensate_reading(input logic [RAW_W-1:0] d1,
                                                    input logic [RAW_W-1:0] d2);
        longint   c1, c2, c3, c4, c5, c6;
        longint   dt, t, off, sens, p, diff;
        reading_t r;
        r = '0;
        if (d1 == '0 || d1 == RAW_ALL_ONES || d2 == '0 || d2 == RAW_ALL_ONES) begin
            r.status = STATUS_ADC_ERR;
            return r;
        end
        c1 = longint'(coef[REG_C1]);
        c2 = longint'(coef[REG_C2]);
        c3 = longint'(coef[REG_C3]);
        c4 = longint'(coef[REG_C4]);
        c5 = longint'(coef[REG_C5]);
        c6 = longint'(coef[REG_C6]);

        dt   = longint'(d2) - c5 * REF_TEMP_MUL;
        t    = TEMP_REF + (dt * c6) / DT_TEMP_DIV;
        off  = c2 * OFF_MUL + (c4 * dt) / OFF_TC_DIV;
        sens = c1 * SENS_MUL + (c3 * dt) / SENS_TC_DIV;

        // low-temperature second-order correction
        if (t < TEMP_REF) begin
            diff = t - TEMP_REF;
            t    = t - (TI_MUL * dt * dt) / TI_DIV;
            off  = off - (OFFI_MUL * diff * diff) / OFFI_DIV;
            sens = sens - (SENSI_MUL * diff * diff) / SENSI_DIV;
        end

        p = ((longint'(d1) * sens) / P_SENS_DIV - off) / P_DIV;

        // range test uses the unsaturated values
        r.status = (p < PRES_MIN || p > PRES_MAX || t < TEMP_MIN || t > TEMP_MAX)
                   ? STATUS_RANGE_ERR : STATUS_OK;

        if (t < TEMP_SAT_MIN) t = TEMP_SAT_MIN;
        if (t > TEMP_SAT_MAX) t = TEMP_SAT_MAX;
        if (p < PRES_SAT_MIN) p = PRES_SAT_MIN;
        if (p > PRES_SAT_MAX) p = PRES_SAT_MAX;
        r.temperature = t[TEMP_W-1:0];
        r.pressure    = p[PRES_W-1:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        reading_t want;
        if (!rst_n) begin
            for (int i = 0; i < 6; i++) coef[i] = '0;
            expected_readings.delete();
            mismatch_count = 0;
            checked_count  = 0;
        end
        else begin
            if (done) begin
                if (expected_readings.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("%0t: result with no transaction outstanding: T=%0d P=%0d S=%0d",
                                 $realtime, temperature, pressure, status);
                end
                else begin
                    want = expected_readings.pop_front();
                    checked_count++;
                    if (temperature !== want.temperature || pressure !== want.pressure ||
                        status !== want.status) begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT)
                            $display("%0t: mismatch exp T=%0d P=%0d S=%0d got T=%0d P=%0d S=%0d",
                                     $realtime, want.temperature, want.pressure, want.status,
                                     temperature, pressure, status);
                    end
                end
            end
            if (start && !busy)
                expected_readings.push_back(compensate_reading(pressure_code, temperature_code));
            // drop writes to indexes past the last coefficient
            if (cfg_we && cfg_index <= REG_C6)
                coef[cfg_index] = cfg_data;
        end
        mismatches       <= mismatch_count;
        pending          <= expected_readings.size();
        readings_checked <= checked_count;
    end

endmodule

// ----- sim/testbench.sv -----
// Top of the compensation unit simulation: clock, reset, coefficient phases and
// bursty raw-sample stimulus. Depends on ptc_pkg, the unit and compensation_checker.
`timescale 1ns / 1ps

module testbench;

    import ptc_pkg::*;

    localparam int CLK_HALF         = 5;
    localparam int RESET_CYCLES     = 9;
    localparam int STALL_LIMIT      = 4000;
    localparam int PHASE_COUNT      = 6;
    localparam int RANDOM_PER_PHASE = 265;

    localparam logic [REG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    localparam logic [COEF_W-1:0] COEF_MAX = '1;
    localparam logic [COEF_W-1:0] TYP_C1   = 16'd34982;
    localparam logic [COEF_W-1:0] TYP_C2   = 16'd36352;
    localparam logic [COEF_W-1:0] TYP_C3   = 16'd20328;
    localparam logic [COEF_W-1:0] TYP_C4   = 16'd22354;
    localparam logic [COEF_W-1:0] TYP_C5   = 16'd26646;
    localparam logic [COEF_W-1:0] TYP_C6   = 16'd26146;

    localparam logic [RAW_W-1:0] TYP_D1    = 24'd4958179;
    localparam logic [RAW_W-1:0] TYP_D2    = 24'd6815414;
    localparam logic [RAW_W-1:0] REF_D2    = 24'd6821376;   // dT = 0 with typical C5
    localparam logic [RAW_W-1:0] RAW_MAX_OK = RAW_ALL_ONES - 24'd1;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       start = 1'b0;
    logic [RAW_W-1:0]           pressure_code = '0;
    logic [RAW_W-1:0]           temperature_code = '0;
    logic                       cfg_we = 1'b0;
    logic [REG_IDX_W-1:0]       cfg_index = '0;
    logic [COEF_W-1:0]          cfg_data = '0;
    logic                       busy;
    logic                       done;
    logic signed [TEMP_W-1:0]   temperature;
    logic signed [PRES_W-1:0]   pressure;
    logic [STATUS_W-1:0]        status;

    int mismatches;
    int pending;
    int readings_checked;
    int items_sent = 0;
    int burst_left = 0;
    int idle_cycles = 0;

    always #CLK_HALF clk = ~clk;

    pressure_temperature_compensation_unit i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .pressure_code    (pressure_code),
        .temperature_code (temperature_code),
        .done             (done),
        .temperature      (temperature),
        .pressure         (pressure),
        .status           (status),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    compensation_checker i_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .pressure_code    (pressure_code),
        .temperature_code (temperature_code),
        .done             (done),
        .temperature      (temperature),
        .pressure         (pressure),
        .status           (status),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .mismatches       (mismatches),
        .pending          (pending),
        .readings_checked (readings_checked)
    );

    // end the run if nothing moves on any channel for too long
    always @(posedge clk) begin
        if (!rst_n || (start && !busy) || done || cfg_we)
            idle_cycles <= 0;
        else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("timeout after %0d idle cycles", idle_cycles);
                $display("pressure_temperature_compensation_unit test failed");
                $finish;
            end
        end
    end

    task automatic write_coefs(input logic [COEF_W-1:0] k1, input logic [COEF_W-1:0] k2,
                               input logic [COEF_W-1:0] k3, input logic [COEF_W-1:0] k4,
                               input logic [COEF_W-1:0] k5, input logic [COEF_W-1:0] k6,
                               input bit with_spares);
        logic [COEF_W-1:0] vals [6];
        vals = '{k1, k2, k3, k4, k5, k6};
        for (int i = 0; i < 6; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= REG_IDX_W'(i);
            cfg_data  <= vals[i];
            @(posedge clk);
        end
        if (with_spares) begin
            cfg_index <= REG_SPARE_LO;
            cfg_data  <= COEF_W'($urandom);
            @(posedge clk);
            cfg_index <= REG_SPARE_HI;
            cfg_data  <= COEF_W'($urandom);
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic send_item(input logic [RAW_W-1:0] d1, input logic [RAW_W-1:0] d2);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 24);
        end
        start            <= 1'b1;
        pressure_code    <= d1;
        temperature_code <= d2;
        @(posedge clk);
        while (busy) @(posedge clk);
        items_sent++;
        burst_left--;
    endtask

    // hold off the sender until every outstanding reading has come back
    task automatic drain_results();
        start <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    function automatic logic [RAW_W-1:0] boundary_raw();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return 24'd1;
            2:       return RAW_MAX_OK;
            3:       return RAW_ALL_ONES;
            default: return RAW_W'($urandom);
        endcase
    endfunction

    function automatic logic [COEF_W-1:0] mixed_coef();
        case ($urandom_range(0, 2))
            0:       return '0;
            1:       return COEF_MAX;
            default: return COEF_W'($urandom);
        endcase
    endfunction

    task automatic pick_pair(output logic [RAW_W-1:0] d1, output logic [RAW_W-1:0] d2);
        int kind;
        int p_val;
        int t_val;
        kind = $urandom_range(0, 99);
        if (kind < 60) begin
            // plausible readings around the typical operating point
            p_val = int'(TYP_D1) + int'($urandom_range(0, 7000000)) - 3000000;
            t_val = int'(TYP_D2) + int'($urandom_range(0, 5000000)) - 2500000;
            d1 = RAW_W'(p_val);
            d2 = RAW_W'(t_val);
        end
        else if (kind < 85) begin
            d1 = RAW_W'($urandom);
            d2 = RAW_W'($urandom);
        end
        else if (kind < 95) begin
            d1 = boundary_raw();
            d2 = boundary_raw();
        end
        else begin
            d1 = RAW_W'($urandom_range(1, 16000000));
            d2 = RAW_W'($urandom_range(1, int'(TYP_D2)));
        end
    endtask

    initial begin
        logic [RAW_W-1:0] d1;
        logic [RAW_W-1:0] d2;
        int               pause_at;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // coefficients still at their reset value
        send_item(TYP_D1, TYP_D2);
        send_item(24'd1, 24'd1);
        send_item(RAW_MAX_OK, RAW_MAX_OK);
        drain_results();

        write_coefs(TYP_C1, TYP_C2, TYP_C3, TYP_C4, TYP_C5, TYP_C6, 1'b0);
        // ADC error codes on either raw field
        send_item('0, TYP_D2);
        send_item(RAW_ALL_ONES, TYP_D2);
        send_item(TYP_D1, '0);
        send_item(TYP_D1, RAW_ALL_ONES);
        send_item('0, RAW_ALL_ONES);
        // extremes of valid raw values
        send_item(24'd1, TYP_D2);
        send_item(RAW_MAX_OK, TYP_D2);
        send_item(TYP_D1, 24'd1);
        send_item(TYP_D1, RAW_MAX_OK);
        send_item(24'd1, 24'd1);
        send_item(RAW_MAX_OK, RAW_MAX_OK);
        // nominal, exactly 20 C, just below 20 C, cold, hot
        send_item(TYP_D1, TYP_D2);
        send_item(TYP_D1, REF_D2);
        send_item(TYP_D1, REF_D2 - 24'd400);
        send_item(TYP_D1, REF_D2 - 24'd1925000);
        send_item(TYP_D1, REF_D2 + 24'd2300000);
        // pressure below and above the valid window
        send_item(24'd1000000, TYP_D2);
        send_item(24'd15000000, TYP_D2);
        drain_results();

        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            case (ph)
                1:       write_coefs(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX,
                                     COEF_MAX, 1'b0);
                2:       write_coefs('0, '0, '0, '0, '0, '0, 1'b0);
                3:       write_coefs(COEF_W'($urandom), COEF_W'($urandom), COEF_W'($urandom),
                                     COEF_W'($urandom), COEF_W'($urandom), COEF_W'($urandom),
                                     1'b0);
                4:       write_coefs(mixed_coef(), mixed_coef(), mixed_coef(), mixed_coef(),
                                     mixed_coef(), mixed_coef(), 1'b0);
                5:       write_coefs(TYP_C1, TYP_C2, TYP_C3, TYP_C4, TYP_C5, TYP_C6, 1'b1);
                default: ;
            endcase
            pause_at = $urandom_range(20, RANDOM_PER_PHASE - 20);
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                if (n == pause_at) drain_results();
                pick_pair(d1, d2);
                send_item(d1, d2);
            end
            drain_results();
        end

        repeat (2 * PIPE_DEPTH) @(posedge clk);
        $display("Sent %0d transactions over %0d coefficient phases, %0d results compared.",
                 items_sent, PHASE_COUNT + 2, readings_checked);
        $display("Covered ADC error codes, raw extremes, both temperature branches, range errors.");
        if (mismatches == 0 && pending == 0)
            $display("pressure_temperature_compensation_unit test passed");
        else
            $display("pressure_temperature_compensation_unit test failed");
        $finish;
    end

endmodule
